// ----- hdl/mexp_pkg.sv -----
// mexp_pkg: shared constants for the 64-bit modular exponentiation block
// used by the channel interfaces and the top level
package mexp_pkg;

    // width of every payload field and of the modulus register
    localparam int FIELD_W = 64;

    // default working word width
    localparam int WORD_BITS_DEF = 64;

    // modulus after reset: 2^64 - 59
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

endpackage

// ----- hdl/mexp_in_if.sv -----
// mexp_in_if: valid/ready channel carrying one base and exponent word
// depends on mexp_pkg for the field width
interface mexp_in_if;

    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::FIELD_W-1:0] base;
    logic [mexp_pkg::FIELD_W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);

endinterface

// ----- hdl/mexp_out_if.sv -----
// mexp_out_if: valid/ready channel carrying one power word
// depends on mexp_pkg for the field width
interface mexp_out_if;

    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::FIELD_W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);

endinterface

// ----- hdl/mexp_step.sv -----
// mexp_step: shared modular add-and-double step, one step per cycle
// no package dependency; width set by WORD_BITS from the top level
module mexp_step #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0] p,
    input  logic [WORD_BITS-1:0] acc,
    input  logic [WORD_BITS-1:0] x,
    input  logic                 sel,
    input  logic                 cin,
    output logic [WORD_BITS-1:0] acc_out,
    output logic [WORD_BITS-1:0] x_out
);

    logic [WORD_BITS:0] pw;
    logic [WORD_BITS:0] dbl;
    logic [WORD_BITS:0] dbl_sub;
    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] sum_sub;

    // double with shifted-in bit, then one conditional subtract (x < p)
    assign pw      = {1'b0, p};
    assign dbl     = {x, cin};
    assign dbl_sub = dbl - pw;
    assign x_out   = (dbl >= pw) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];

    // accumulate x when selected, then one conditional subtract (acc, x < p)
    assign sum     = {1'b0, acc} + {1'b0, x};
    assign sum_sub = sum - pw;

    always_comb
    begin
        if (!sel)
        begin
            acc_out = acc;
        end
        else if (sum >= pw)
        begin
            acc_out = sum_sub[WORD_BITS-1:0];
        end
        else
        begin
            acc_out = sum[WORD_BITS-1:0];
        end
    end

endmodule

// ----- hdl/modular_exponentiation_64_unit.sv -----
// modular_exponentiation_64_unit: base^exponent mod modulus, square and multiply
// sequence: the base is first reduced modulo the modulus, then each exponent bit, msb first,
//   takes a squaring and, when set, a multiply by the base; then the power is loaded (0 if modulus < 2)
// one word at a time on the shared step unit: a new word is taken only in the idle state;
//   a held power word keeps the sequencer in its finish state
// reset: async active low; modulus returns to 2^64-59, sequencer idle, output empty
module modular_exponentiation_64_unit #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mexp_pkg::FIELD_W-1:0]   cfg_data,
    mexp_in_if.sink                        req,
    mexp_out_if.source                     rsp
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_MUL    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [mexp_pkg::FIELD_W-1:0] modulus_reg;
    logic [1:0]           state_reg,  state_next;
    logic [WORD_BITS-1:0] b_reg,      b_next;
    logic [WORD_BITS-1:0] e_reg,      e_next;
    logic [WORD_BITS-1:0] r_reg,      r_next;
    logic [WORD_BITS-1:0] acc_reg,    acc_next;
    logic [WORD_BITS-1:0] x_reg,      x_next;
    logic [WORD_BITS-1:0] y_reg,      y_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [CNT_W-1:0]     ecnt_reg,   ecnt_next;
    logic                 mulph_reg,  mulph_next;
    logic [WORD_BITS-1:0] power_reg,  power_next;
    logic                 ovalid_reg, ovalid_next;

    logic [WORD_BITS-1:0] p;
    logic                 p_small;
    logic                 step_sel;
    logic                 step_cin;
    logic [WORD_BITS-1:0] step_acc;
    logic [WORD_BITS-1:0] step_x;
    logic                 accept;
    logic                 load_out;

    assign p       = modulus_reg[WORD_BITS-1:0];
    assign p_small = (p < WORD_BITS'(2));
    assign accept  = req.valid && req.ready;

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mexp_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_data;
        end
    end

    // shared step unit
    assign step_sel = (state_reg == ST_MUL) && y_reg[0];
    assign step_cin = (state_reg == ST_REDUCE) && b_reg[WORD_BITS-1];

    mexp_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .p       (p),
        .acc     (acc_reg),
        .x       (x_reg),
        .sel     (step_sel),
        .cin     (step_cin),
        .acc_out (step_acc),
        .x_out   (step_x)
    );

    assign load_out = (state_reg == ST_FINISH) && (!ovalid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        ecnt_next  = ecnt_reg;
        mulph_next = mulph_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    b_next    = req.base[WORD_BITS-1:0];
                    e_next    = req.exponent[WORD_BITS-1:0];
                    x_next    = '0;
                    cnt_next  = '0;
                    ecnt_next = '0;
                    if (p_small)
                    begin
                        r_next     = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                // shift base bits in msb first, keeping the remainder below p
                b_next   = b_reg << 1;
                x_next   = step_x;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    // reduced base kept, start squaring of r = 1
                    b_next     = step_x;
                    r_next     = ONE;
                    x_next     = ONE;
                    y_next     = ONE;
                    acc_next   = '0;
                    cnt_next   = '0;
                    mulph_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // one add-and-double step of the modular product
                acc_next = step_acc;
                x_next   = step_x;
                y_next   = y_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    r_next   = step_acc;
                    acc_next = '0;
                    cnt_next = '0;
                    if (!mulph_reg && e_reg[WORD_BITS-1])
                    begin
                        // exponent bit set: multiply by the base
                        mulph_next = 1'b1;
                        x_next     = step_acc;
                        y_next     = b_reg;
                    end
                    else
                    begin
                        // next exponent bit
                        mulph_next = 1'b0;
                        e_next     = e_reg << 1;
                        ecnt_next  = ecnt_reg + CNT_W'(1);
                        x_next     = step_acc;
                        y_next     = step_acc;
                        if (ecnt_reg == CNT_LAST)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        power_next  = power_reg;
        ovalid_next = ovalid_reg;
        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (load_out)
        begin
            power_next  = r_reg;
            ovalid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ecnt_reg   <= '0;
            mulph_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ecnt_reg   <= ecnt_next;
            mulph_reg  <= mulph_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        e_reg     <= e_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        power_reg <= power_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.power = mexp_pkg::FIELD_W'(power_reg);

endmodule
